// ----- hdl/sorted_edit_mark_table_top_defines.svh -----
// Assertion macros used by the port-level checker file.
`ifndef SORTED_EDIT_MARK_TABLE_TOP_DEFINES_SVH
`define SORTED_EDIT_MARK_TABLE_TOP_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define SEMT_ASSERT_IMPL(lbl, clk, rst_n, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define SEMT_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("next-cycle check failed");

// Check that a signal holds over a stalled beat.
`define SEMT_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) ((vld) && !(rdy)) |=> \
		((vld) && $stable(sig))) else $error("stalled beat changed");

`endif

// ----- hdl/semt_pkg.sv -----
// Shared constants and types of the sorted edit mark table.
package semt_pkg;
	localparam int MAX_MARKS = 64;
	localparam int POS_BITS = 24;
	localparam int ADDR_W = $clog2(MAX_MARKS);
	localparam int CNT_W = $clog2(MAX_MARKS + 1);
	localparam int OUT_CNT_W = 7;
	localparam int OUT_W = 72;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_QUERY  = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_INS_RD = 5'b00010,
		ST_INS_CMP = 5'b00100,
		ST_SCAN   = 5'b01000,
		ST_FIN    = 5'b10000
	} state_t;
endpackage

// ----- hdl/sorted_edit_mark_table_top.sv -----
// Sorted edit mark table: insert, query, clear and sequence count over a sorted mark memory.
// Operation: an insert shifts larger marks up one slot at a time from the top until its place is found,
// then a scan reads the stored marks in order, then the result loads into the output register.
// Items are taken one at a time: the next beat is accepted only after the result loads, and
// an output beat that is not yet accepted holds off the load.
// Reset: arst_n clears the mark count and control; memory contents stay undefined.
module sorted_edit_mark_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // query_position
	input  logic [1:0]  s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status, exact_hit, prev_valid, prev_position, next_valid, next_position,
	// mark_count, sequence_count, zero fill
	output logic [71:0] m_axis_tdata
);
	localparam int AW = semt_pkg::ADDR_W;
	localparam int CW = semt_pkg::CNT_W;
	localparam int PW = semt_pkg::POS_BITS;
	localparam int OW = semt_pkg::OUT_CNT_W;

	logic [PW-1:0] mem [semt_pkg::MAX_MARKS];
	logic [PW-1:0] rdata;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [PW-1:0] wdata;

	semt_pkg::state_t  state_q, state_d;
	semt_pkg::action_t act_q;
	logic [PW-1:0] pos_q;
	logic          status_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] ri_q;
	logic          rv_s1;
	logic          held_v_q;
	logic [PW-1:0] held_q;
	logic          phase_q;
	logic [PW-1:0] beg_q;
	logic [CW-1:0] seq_q;
	logic          hit_q, pv_q, nv_q;
	logic [PW-1:0] pp_q, np_q;

	logic          ph_f;
	logic [PW-1:0] beg_f;
	logic [CW-1:0] seq_f;
	logic [CW-1:0] seq_out;
	logic          scan_issue;

	assign s_axis_tready = (state_q == semt_pkg::ST_IDLE);
	assign scan_issue = (ri_q < count_q);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

	always_comb begin
		state_d = state_q;
		raddr = ri_q[AW-1:0];
		we = 1'b0;
		waddr = i_q[AW-1:0];
		wdata = pos_q;
		unique case (state_q)
			semt_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (semt_pkg::action_t'(s_axis_tuser) == semt_pkg::ACT_INSERT &&
							count_q < CW'(semt_pkg::MAX_MARKS)) begin
						state_d = semt_pkg::ST_INS_RD;
					end else begin
						state_d = semt_pkg::ST_SCAN;
					end
				end
			end
			semt_pkg::ST_INS_RD: begin
				raddr = AW'(i_q - CW'(1));
				if (i_q == '0) begin
					we = 1'b1;
					state_d = semt_pkg::ST_SCAN;
				end else begin
					state_d = semt_pkg::ST_INS_CMP;
				end
			end
			semt_pkg::ST_INS_CMP: begin
				we = 1'b1;
				if (rdata > pos_q) begin
					wdata = rdata;
					state_d = semt_pkg::ST_INS_RD;
				end else begin
					state_d = semt_pkg::ST_SCAN;
				end
			end
			semt_pkg::ST_SCAN: begin
				if (!scan_issue && !rv_s1) begin
					state_d = semt_pkg::ST_FIN;
				end
			end
			semt_pkg::ST_FIN: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					state_d = semt_pkg::ST_IDLE;
				end
			end
			default: state_d = semt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ph_f = phase_q;
		beg_f = beg_q;
		seq_f = seq_q;
		if (held_v_q) begin
			if (!phase_q) begin
				ph_f = 1'b1;
				beg_f = held_q;
			end else begin
				ph_f = 1'b0;
				seq_f = seq_q + CW'(1);
			end
		end
		seq_out = seq_f;
		if (ph_f) begin
			seq_out = seq_f + CW'(1);
			if (seq_f == '0 && beg_f == '0) begin
				seq_out = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= semt_pkg::ST_IDLE;
			count_q <= '0;
			m_axis_tvalid <= 1'b0;
			rv_s1 <= 1'b0;
			ri_q <= '0;
			held_v_q <= 1'b0;
			phase_q <= 1'b0;
			seq_q <= '0;
			hit_q <= 1'b0;
			pv_q <= 1'b0;
			nv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == semt_pkg::ST_FIN && (!m_axis_tvalid || m_axis_tready)) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			if (state_q == semt_pkg::ST_IDLE && s_axis_tvalid) begin
				if (semt_pkg::action_t'(s_axis_tuser) == semt_pkg::ACT_CLEAR) begin
					count_q <= '0;
				end
			end
			if (state_q == semt_pkg::ST_INS_RD && i_q == '0) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == semt_pkg::ST_INS_CMP && !(rdata > pos_q)) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q != semt_pkg::ST_SCAN && state_q != semt_pkg::ST_FIN) begin
				rv_s1 <= 1'b0;
				ri_q <= '0;
				held_v_q <= 1'b0;
				phase_q <= 1'b0;
				seq_q <= '0;
				hit_q <= 1'b0;
				pv_q <= 1'b0;
				nv_q <= 1'b0;
			end else begin
				rv_s1 <= scan_issue;
				if (scan_issue) begin
					ri_q <= ri_q + CW'(1);
				end
				if (rv_s1) begin
					if (act_q == semt_pkg::ACT_QUERY) begin
						if (rdata == pos_q) begin
							hit_q <= 1'b1;
						end
						if (rdata < pos_q) begin
							pv_q <= 1'b1;
						end
						if (rdata > pos_q && !nv_q) begin
							nv_q <= 1'b1;
						end
					end
					if (held_v_q) begin
						if (held_q == rdata) begin
							held_v_q <= 1'b0;
						end else begin
							phase_q <= ~phase_q;
							if (phase_q) begin
								seq_q <= seq_q + CW'(1);
							end
						end
					end else begin
						held_v_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == semt_pkg::ST_IDLE && s_axis_tvalid) begin
			act_q <= semt_pkg::action_t'(s_axis_tuser);
			pos_q <= PW'(s_axis_tdata);
			i_q <= count_q;
			status_q <= (semt_pkg::action_t'(s_axis_tuser) == semt_pkg::ACT_INSERT) &&
				(count_q >= CW'(semt_pkg::MAX_MARKS));
		end
		if (state_q == semt_pkg::ST_INS_CMP && rdata > pos_q) begin
			i_q <= i_q - CW'(1);
		end
		if (state_q == semt_pkg::ST_SCAN && rv_s1) begin
			if (act_q == semt_pkg::ACT_QUERY) begin
				if (rdata < pos_q) begin
					pp_q <= rdata;
				end
				if (rdata > pos_q && !nv_q) begin
					np_q <= rdata;
				end
			end
			if (held_v_q) begin
				if (held_q != rdata) begin
					if (!phase_q) begin
						beg_q <= held_q;
					end
					held_q <= rdata;
				end
			end else begin
				held_q <= rdata;
			end
		end
		if (state_q == semt_pkg::ST_FIN && (!m_axis_tvalid || m_axis_tready)) begin
			m_axis_tdata <= {6'd0, OW'(seq_out), OW'(count_q),
				nv_q ? np_q : {PW{1'b0}}, nv_q,
				pv_q ? pp_q : {PW{1'b0}}, pv_q, hit_q, status_q};
		end
	end
endmodule

// ----- hdl/semt_checker.sv -----
// Port-level checker for the sorted edit mark table, bound to the top level.
`include "sorted_edit_mark_table_top_defines.svh"

module semt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata
);
	`SEMT_ASSERT_IMPL(a_pad_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[71:66] == 6'd0)
	`SEMT_ASSERT_IMPL(a_cnt_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[58:52] <= 7'd64)
	`SEMT_ASSERT_IMPL(a_prev_zero, clk, arst_n, m_axis_tvalid && !m_axis_tdata[2], m_axis_tdata[26:3] == 24'd0)
	`SEMT_ASSERT_NEXT(a_busy_after_in, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`SEMT_ASSERT_HOLD(a_out_hold, clk, arst_n, m_axis_tvalid, m_axis_tready, m_axis_tdata)
endmodule

bind sorted_edit_mark_table_top semt_checker u_semt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
